// File: rtl/rational_switch_coordination_sum_defines.svh
// Assertion macros for the rational switch coordination sum block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef RATIONAL_SWITCH_COORDINATION_SUM_DEFINES_SVH
`define RATIONAL_SWITCH_COORDINATION_SUM_DEFINES_SVH

// Same-cycle implication or plain property, sampled on clk_i.
`define RSCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define RSCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rscs_pkg.sv
// Shared types and constants for the rational switch coordination sum block.
// No dependencies; compiled first.
package rscs_pkg;

  localparam int D2_W     = 48;  // squared distance, Q16.32
  localparam int CFG_W    = 24;  // d0 / r0, Q8.16
  localparam int HALF_W   = 3;
  localparam int CIDX_W   = 2;
  localparam int ROOT_W   = 24;  // sqrt result, Q8.16
  localparam int SQREM_W  = 25;
  localparam int X_W      = 40;  // x, x2, p, Q24.16
  localparam int DIVD_W   = 40;  // divider dividend / quotient
  localparam int DIVS_W   = 41;  // divider divisor
  localparam int DIG_W    = 16;  // multiplier digit
  localparam int MULA_W   = 48;  // multiplicand padded to whole digits
  localparam int ACC_W    = 80;  // full product
  localparam int TERM_W   = 17;  // term, Q1.16, up to 1.0
  localparam int SUM_W    = 29;  // Q13.16
  localparam int STEP_W   = 6;

  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = DIVD_W;
  localparam int MUL_DIGITS = MULA_W / DIG_W;

  localparam int MAX_PAIRS = 4096;
  localparam longint unsigned LIMIT_RAW = longint'(MAX_PAIRS) << 16;
  localparam longint unsigned SUM_FIELD_MAX = (64'd1 << SUM_W) - 64'd1;
  localparam logic [SUM_W-1:0] SUM_LIMIT =
    (LIMIT_RAW > SUM_FIELD_MAX) ? SUM_W'(SUM_FIELD_MAX) : SUM_W'(LIMIT_RAW);

  localparam logic [X_W-1:0] ONE_Q16 = X_W'(65536);
  localparam logic [DIVD_W-1:0] TWO_POW32 = DIVD_W'(64'd1 << 32);

  localparam logic [CFG_W-1:0]  CENTER_RST = CFG_W'(78643);  // about 1.2
  localparam logic [CFG_W-1:0]  WIDTH_RST  = CFG_W'(78643);  // about 1.2
  localparam logic [HALF_W-1:0] HALF_RST   = HALF_W'(3);     // n = 6

  typedef enum logic [CIDX_W-1:0] {
    CFG_CENTER = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HALF   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_DIVX_SETUP,
    ST_DIVX,
    ST_MULX2_SETUP,
    ST_MULP_SETUP,
    ST_MUL,
    ST_MUL_END,
    ST_POW_CHECK,
    ST_DIVT_SETUP,
    ST_DIVT,
    ST_TERM_LOAD,
    ST_ACCUM
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQRT,
    OP_DIVX_INIT,
    OP_DIV_STEP,
    OP_MULX2_INIT,
    OP_MULP_INIT,
    OP_MUL_STEP,
    OP_MUL_END_X2,
    OP_MUL_END_P,
    OP_DIVT_INIT,
    OP_TERM_LOAD,
    OP_TERM_ZERO,
    OP_ACCUM
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic              width_zero;
    logic [HALF_W-1:0] half;
    logic              ovf;
    logic              out_busy;
  } dp_stat_t;

endpackage

// File: rtl/rscs_if.sv
// Valid/ready channel interfaces: pair input, result output, config write.
// Depends on rscs_pkg for widths.
interface rscs_in_if
  import rscs_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [D2_W-1:0] squared_distance;
  logic            last_pair;

  modport source (output valid, squared_distance, last_pair, input ready);
  modport sink   (input valid, squared_distance, last_pair, output ready);
endinterface

interface rscs_out_if
  import rscs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] coordination_sum;
  logic             saturated;

  modport source (output valid, coordination_sum, saturated, input ready);
  modport sink   (input valid, coordination_sum, saturated, output ready);
endinterface

interface rscs_cfg_if
  import rscs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CFG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/rscs_div.sv
// Restoring radix-2 divider, one quotient bit per step, shared by x and term.
// Depends on rscs_pkg.
module rscs_div
  import rscs_pkg::*;
(
  input  logic              clk_i,
  input  logic              start_i,
  input  logic              step_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic [DIVD_W-1:0] quotient_o
);

  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic [DIVS_W:0]   trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    trial = {rem_q, quo_q[DIVD_W-1]};
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (step_i) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DIVS_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIVS_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;

endmodule

// File: rtl/rscs_dpath.sv
// Datapath: config registers, bit-serial sqrt, digit-serial multiplier,
// shared divider, running sum and output register. Depends on rscs_pkg, rscs_div.
module rscs_dpath
  import rscs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic [D2_W-1:0]   d2_i,
  input  logic              last_i,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SUM_W-1:0]  out_sum_o,
  output logic              out_sat_o
);

  logic [CFG_W-1:0]   center_q, width_q;
  logic [HALF_W-1:0]  half_q;

  logic [D2_W-1:0]    sq_v_q;
  logic [SQREM_W-1:0] sq_rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic               last_q;

  logic [MULA_W-1:0]  mul_a_q;
  logic [X_W-1:0]     mul_b_q;
  logic [ACC_W-1:0]   acc_q;
  logic [X_W-1:0]     x2_q, p_q;
  logic               ovf_q;
  logic [TERM_W-1:0]  term_q;

  logic [SUM_W-1:0]   run_q;
  logic               clamp_q;
  logic               out_valid_q;
  logic [SUM_W-1:0]   out_sum_q;
  logic               out_sat_q;

  logic [SQREM_W+1:0] sq_trial, sq_cand;
  logic [ROOT_W-1:0]  diff;
  logic [DIG_W+X_W-1:0] pp;
  logic [ACC_W-1:0]   acc_next;
  logic [DIVS_W-1:0]  den;
  logic [SUM_W:0]     sum_raw;
  logic               sum_over;

  logic               div_start, div_step;
  logic [DIVD_W-1:0]  div_dividend, div_quo;
  logic [DIVS_W-1:0]  div_divisor;

  always_comb begin
    sq_trial = {sq_rem_q, sq_v_q[D2_W-1 -: 2]};
    sq_cand  = {1'b0, root_q, 2'b01};
    diff     = (root_q >= center_q) ? (root_q - center_q) : (center_q - root_q);
    pp       = mul_a_q[MULA_W-1 -: DIG_W] * mul_b_q;
    acc_next = {acc_q[ACC_W-DIG_W-1:0], {DIG_W{1'b0}}} + ACC_W'(pp);
    den      = {1'b0, p_q} + DIVS_W'(ONE_Q16);
    sum_raw  = {1'b0, run_q} + (SUM_W+1)'(term_q);
    sum_over = sum_raw > {1'b0, SUM_LIMIT};
  end

  assign div_start = (cmd_i.op == OP_DIVX_INIT) || (cmd_i.op == OP_DIVT_INIT);
  assign div_step  = (cmd_i.op == OP_DIV_STEP);

  always_comb begin
    if (cmd_i.op == OP_DIVT_INIT) begin
      div_dividend = TWO_POW32 + DIVD_W'(den >> 1);
      div_divisor  = den;
    end else begin
      div_dividend = {diff, {DIG_W{1'b0}}};
      div_divisor  = DIVS_W'(width_q);
    end
  end

  rscs_div u_div (
    .clk_i      (clk_i),
    .start_i    (div_start),
    .step_i     (div_step),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CENTER_RST;
      width_q  <= WIDTH_RST;
      half_q   <= HALF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CENTER: center_q <= cfg_data_i;
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HALF:   half_q   <= cfg_data_i[HALF_W-1:0];
        default:    ;
      endcase
    end
  end

  // arithmetic payload
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        sq_v_q   <= d2_i;
        sq_rem_q <= '0;
        root_q   <= '0;
        last_q   <= last_i;
      end
      OP_SQRT: begin
        sq_v_q <= {sq_v_q[D2_W-3:0], 2'b00};
        if (sq_trial >= sq_cand) begin
          sq_rem_q <= SQREM_W'(sq_trial - sq_cand);
          root_q   <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_q <= sq_trial[SQREM_W-1:0];
          root_q   <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      OP_DIVX_INIT: p_q <= ONE_Q16;
      OP_MULX2_INIT: begin
        mul_a_q <= MULA_W'(div_quo);
        mul_b_q <= div_quo;
        acc_q   <= '0;
      end
      OP_MULP_INIT: begin
        mul_a_q <= MULA_W'(p_q);
        mul_b_q <= x2_q;
        acc_q   <= '0;
      end
      OP_MUL_STEP: begin
        mul_a_q <= {mul_a_q[MULA_W-DIG_W-1:0], {DIG_W{1'b0}}};
        acc_q   <= acc_next;
      end
      OP_MUL_END_X2: begin
        x2_q  <= acc_q[DIG_W +: X_W];
        ovf_q <= |acc_q[ACC_W-1:DIG_W+X_W];
      end
      OP_MUL_END_P: begin
        p_q   <= acc_q[DIG_W +: X_W];
        ovf_q <= |acc_q[ACC_W-1:DIG_W+X_W];
      end
      OP_TERM_LOAD: term_q <= div_quo[TERM_W-1:0];
      OP_TERM_ZERO: term_q <= '0;
      OP_ACCUM: begin
        if (last_q) begin
          out_sum_q <= sum_over ? SUM_LIMIT : sum_raw[SUM_W-1:0];
          out_sat_q <= clamp_q | sum_over;
        end
      end
      default: ;
    endcase
  end

  // running sum and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      clamp_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if ((cmd_i.op == OP_ACCUM) && last_q) begin
      run_q       <= '0;
      clamp_q     <= 1'b0;
      out_valid_q <= 1'b1;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.op == OP_ACCUM) begin
        run_q   <= sum_over ? SUM_LIMIT : sum_raw[SUM_W-1:0];
        clamp_q <= clamp_q | sum_over;
      end
    end
  end

  assign stat_o.width_zero = (width_q == '0);
  assign stat_o.half       = half_q;
  assign stat_o.ovf        = ovf_q;
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_sum_o   = out_sum_q;
  assign out_sat_o   = out_sat_q;

endmodule

// File: rtl/rscs_ctrl.sv
// Controller FSM: sequences sqrt, divide, power and accumulate steps.
// Depends on rscs_pkg; drives rscs_dpath through dp_cmd_t.
module rscs_ctrl
  import rscs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [HALF_W-1:0] pow_q, pow_d;
  logic              cnt_last_sqrt, cnt_last_div, cnt_last_mul;

  assign cnt_last_sqrt = (cnt_q == STEP_W'(SQRT_STEPS - 1));
  assign cnt_last_div  = (cnt_q == STEP_W'(DIV_STEPS - 1));
  assign cnt_last_mul  = (cnt_q == STEP_W'(MUL_DIGITS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pow_d   = pow_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        pow_d = '0;
        if (in_valid_i) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_last_sqrt) begin
          cnt_d   = '0;
          state_d = ST_DIVX_SETUP;
        end
      end
      ST_DIVX_SETUP: state_d = stat_i.width_zero ? ST_ACCUM : ST_DIVX;
      ST_DIVX: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_last_div) begin
          cnt_d   = '0;
          state_d = (stat_i.half == '0) ? ST_DIVT_SETUP : ST_MULX2_SETUP;
        end
      end
      ST_MULX2_SETUP: state_d = ST_MUL;
      ST_MULP_SETUP: begin
        pow_d   = pow_q + 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_last_mul) begin
          cnt_d   = '0;
          state_d = ST_MUL_END;
        end
      end
      ST_MUL_END: state_d = ST_POW_CHECK;
      ST_POW_CHECK: begin
        if (stat_i.ovf)                state_d = ST_ACCUM;
        else if (pow_q == stat_i.half) state_d = ST_DIVT_SETUP;
        else                           state_d = ST_MULP_SETUP;
      end
      ST_DIVT_SETUP: state_d = ST_DIVT;
      ST_DIVT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_last_div) begin
          cnt_d   = '0;
          state_d = ST_TERM_LOAD;
        end
      end
      ST_TERM_LOAD: state_d = ST_ACCUM;
      ST_ACCUM: if (!stat_i.out_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_SQRT:        cmd_o.op = OP_SQRT;
      ST_DIVX_SETUP:  cmd_o.op = stat_i.width_zero ? OP_TERM_ZERO : OP_DIVX_INIT;
      ST_DIVX:        cmd_o.op = OP_DIV_STEP;
      ST_MULX2_SETUP: cmd_o.op = OP_MULX2_INIT;
      ST_MULP_SETUP:  cmd_o.op = OP_MULP_INIT;
      ST_MUL:         cmd_o.op = OP_MUL_STEP;
      ST_MUL_END:     cmd_o.op = (pow_q == '0) ? OP_MUL_END_X2 : OP_MUL_END_P;
      ST_POW_CHECK:   if (stat_i.ovf) cmd_o.op = OP_TERM_ZERO;
      ST_DIVT_SETUP:  cmd_o.op = OP_DIVT_INIT;
      ST_DIVT:        cmd_o.op = OP_DIV_STEP;
      ST_TERM_LOAD:   cmd_o.op = OP_TERM_LOAD;
      ST_ACCUM:       if (!stat_i.out_busy) cmd_o.op = OP_ACCUM;
      default:        cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pow_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pow_q   <= pow_d;
    end
  end

endmodule

// File: rtl/rational_switch_coordination_sum.sv
// Top level of the rational switch coordination sum block.
// Depends on rscs_pkg, rscs_if, rscs_ctrl, rscs_dpath (with rscs_div).
//
//   channel  dir  modport  payload
//   in_i     in   sink     squared_distance[47:0] (Q16.32), last_pair
//   cfg_i    in   sink     index[1:0], data[23:0]
//   out_o    out  source   coordination_sum[28:0] (Q13.16), saturated
//
// One pair per transaction; in_i.ready is high only in IDLE. From accept
//   back to IDLE the FSM runs the 24-step sqrt, a 40-step divider pass for x,
//   half_exponent+1 digit-serial multiplies of 3 digits (with setup/end/check)
//   unless half_exponent is 0, and a 40-step divider pass for the term.
// A result waits in the output register; the next pair is accepted meanwhile.
//   The accumulate step of any pair stalls while that register is full and out_o.ready is low.
// Reset (rst_ni, async low) clears the FSM, sum, clamp flag and output valid,
//   and loads config defaults d0 = r0 = 78643, half_exponent = 3.
// cfg_i is always ready; writes to the unused index are dropped.
module rational_switch_coordination_sum
  import rscs_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  rscs_in_if.sink    in_i,
  rscs_cfg_if.sink   cfg_i,
  rscs_out_if.source out_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  // config port never back-pressures
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  rscs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rscs_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .d2_i        (in_i.squared_distance),
    .last_i      (in_i.last_pair),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_sum_o   (out_o.coordination_sum),
    .out_sat_o   (out_o.saturated)
  );

endmodule

// File: rtl/rscs_checker.sv
// Port-level checker for the coordination sum block, bound to the top level.
// Depends on rscs_pkg and the defines header.
`include "rational_switch_coordination_sum_defines.svh"

module rscs_checker
  import rscs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SUM_W-1:0] out_sum,
  input logic             out_sat
);

  `RSCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `RSCS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_sum) && $stable(out_sat), "result changed while stalled")
  `RSCS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second pair taken while busy")
  `RSCS_ASSERT(a_sum_bound, !out_valid || (out_sum <= SUM_LIMIT && (!out_sat || out_sum == SUM_LIMIT)), "sum beyond limit or flag without clamp value")

endmodule

bind rational_switch_coordination_sum rscs_checker u_rscs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_sum   (out_o.coordination_sum),
  .out_sat   (out_o.saturated)
);
